>>> design/whc_pkg.sv
// Package with the request and result types and the constants of the WAV header checker.
package whc_pkg;

  // Header length in bytes, used as the default of the top level parameter.
  localparam int HeaderBytesDef = 44;

  // Tags, read with the first byte of the tag in the most significant byte.
  localparam logic [31:0] TagRiff = 32'h5249_4646;
  localparam logic [31:0] TagWave = 32'h5741_5645;
  localparam logic [31:0] TagFmt  = 32'h666D_7420;
  localparam logic [31:0] TagData = 32'h6461_7461;

  // Byte positions of the header fields.
  localparam logic [8:0] PosRiffEnd  = 9'd3;
  localparam logic [8:0] PosWaveEnd  = 9'd11;
  localparam logic [8:0] PosFmtEnd   = 9'd15;
  localparam logic [8:0] PosRateBeg  = 9'd24;
  localparam logic [8:0] PosRateEnd  = 9'd27;
  localparam logic [8:0] ScanFirst   = 9'd36;
  localparam logic [8:0] DataSkip    = 9'd8;

  // Error flag bit indexes.
  localparam int ErrShort = 0;
  localparam int ErrRiff  = 1;
  localparam int ErrWave  = 2;
  localparam int ErrFmt   = 3;
  localparam int ErrRate  = 4;
  localparam int ErrData  = 5;

  // Configuration register addresses (bit 2 of the byte address).
  localparam logic RegExpectedRate = 1'b0;
  localparam logic RegScanEnd      = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [31:0] ExpectedRateRst = 32'd8000;
  localparam logic [7:0]  ScanEndRst      = 8'd100;

  // One input request: a byte of the file and its markers.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_stream;
  } in_req_t;

  // One result: the verdict on the header.
  typedef struct packed {
    logic [5:0] error_flags;
    logic       header_ok;
    logic [8:0] audio_offset;
  } out_res_t;

endpackage

>>> design/wav_header_checker.sv
// Top level of the WAV header checker: channels, configuration port and result register.
//
//  Channel  | Ports                                    | Moves
//  ---------+------------------------------------------+------------------------------
//  input    | in_valid, in_stall, in_req               | one file byte per request
//  result   | out_valid, out_stall, out_res            | one verdict per file
//  config   | psel, penable, pwrite, paddr, pwdata,    | expected_rate at 0x0,
//           | prdata, pready                           | scan_end at 0x4
//
// One byte is taken every cycle while in_stall is low; its verdict, if it gives one, reaches
// the result register by way of the input register: the byte waits in the input register
// and passes the parser logic into the result register when that register can take it.
// A stalled result holds the parser; the input register then fills and in_stall rises.
// After reset the checker ignores bytes until one arrives with start_of_file set.
module wav_header_checker #(
  parameter int HEADER_BYTES = whc_pkg::HeaderBytesDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  whc_pkg::in_req_t  in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output whc_pkg::out_res_t out_res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [31:0]       rate_cfg_r;
  logic [7:0]        scan_end_r;
  logic              in_valid_r, in_valid_nxt;
  whc_pkg::in_req_t  in_req_r;
  logic              out_valid_r, out_valid_nxt;
  whc_pkg::out_res_t out_res_r;
  logic              advance;
  logic              step_en;
  logic              accept;
  logic              emit;
  whc_pkg::out_res_t res;
  logic              cfg_wr;

  // Configuration registers, written in the access phase of a write.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_cfg_r <= whc_pkg::ExpectedRateRst;
      scan_end_r <= whc_pkg::ScanEndRst;
    end else if (cfg_wr) begin
      case (paddr[2])
        whc_pkg::RegExpectedRate: rate_cfg_r <= pwdata;
        whc_pkg::RegScanEnd:      scan_end_r <= pwdata[7:0];
        default:                  rate_cfg_r <= rate_cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      whc_pkg::RegExpectedRate: prdata = rate_cfg_r;
      whc_pkg::RegScanEnd:      prdata = {24'd0, scan_end_r};
      default:                  prdata = '0;
    endcase
  end

  // Input register: it moves on whenever the result register can take a verdict.
  assign advance  = !out_valid_r || !out_stall;
  assign step_en  = in_valid_r && advance;
  assign in_stall = in_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_req_r <= in_req;
    end
  end

  // Parser with the file state.
  whc_parser #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (step_en),
    .req          (in_req_r),
    .expected_rate(rate_cfg_r),
    .scan_end     (scan_end_r),
    .emit         (emit),
    .res          (res)
  );

  // Result register, held while the receiver stalls.
  always_comb begin
    if (step_en && emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && emit) begin
      out_res_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTH
  // A clean header always comes with the offset of its audio data.
  a_ok_has_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.header_ok |-> out_res.audio_offset != '0)
    else $error("clean header reported without an audio offset");

  // A found data tag starts no earlier than byte 36, so its audio lies at 44 or later.
  a_offset_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.audio_offset != '0 |-> out_res.audio_offset >= 9'd44)
    else $error("audio offset lies inside the fixed header");

  // The no-data flag and a found offset exclude each other.
  a_data_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.error_flags[whc_pkg::ErrData] == (out_res.audio_offset == '0))
    else $error("no-data flag disagrees with the audio offset");

  // Input is held back only while a byte waits behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid_r && out_stall)
    else $error("input stalled without a waiting result");
`endif

endmodule

>>> design/whc_parser.sv
// Header parser: file state and the per-byte checks that lead to a verdict.
module whc_parser #(
  parameter int HEADER_BYTES = whc_pkg::HeaderBytesDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  whc_pkg::in_req_t   req,
  input  logic [31:0]        expected_rate,
  input  logic [7:0]         scan_end,
  output logic               emit,
  output whc_pkg::out_res_t  res
);

  localparam logic [8:0] LastHdr = 9'(HEADER_BYTES - 1);

  logic [8:0]  pos_r, pos_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] last4_r, last4_nxt;
  logic [5:0]  err_r, err_nxt;
  logic        fin_r, fin_nxt;
  logic [8:0]  doff_r, doff_nxt;

  logic [8:0]  p;
  logic [31:0] rate_cur;
  logic [5:0]  err_cur;
  logic [8:0]  doff_cur;
  logic        live;
  logic [8:0]  win;
  logic [8:0]  lo;
  logic        resolved;
  logic [5:0]  err_fin;

  // A start of file drops the check in progress; otherwise work from stored state.
  always_comb begin
    p        = req.start_of_file ? '0 : pos_r;
    rate_cur = req.start_of_file ? '0 : rate_r;
    err_cur  = req.start_of_file ? '0 : err_r;
    doff_cur = req.start_of_file ? '0 : doff_r;
    live     = req.start_of_file || !fin_r;
  end

  // Tag checks, rate assembly and data tag search for the current byte.
  always_comb begin
    last4_nxt = {(req.start_of_file ? 24'd0 : last4_r[23:0]), req.data_byte};
    rate_nxt  = rate_cur;
    err_nxt   = err_cur;
    doff_nxt  = doff_cur;
    win       = p - 9'd3;

    if (p == whc_pkg::PosRiffEnd && last4_nxt != whc_pkg::TagRiff) begin
      err_nxt[whc_pkg::ErrRiff] = 1'b1;
    end
    if (p == whc_pkg::PosWaveEnd && last4_nxt != whc_pkg::TagWave) begin
      err_nxt[whc_pkg::ErrWave] = 1'b1;
    end
    if (p == whc_pkg::PosFmtEnd && last4_nxt != whc_pkg::TagFmt) begin
      err_nxt[whc_pkg::ErrFmt] = 1'b1;
    end

    // The rate is little endian; positions 24 to 27 map to byte lanes 0 to 3.
    if (p inside {[whc_pkg::PosRateBeg:whc_pkg::PosRateEnd]}) begin
      case (p[1:0])
        2'd0:    rate_nxt[7:0]   = rate_cur[7:0]   | req.data_byte;
        2'd1:    rate_nxt[15:8]  = rate_cur[15:8]  | req.data_byte;
        2'd2:    rate_nxt[23:16] = rate_cur[23:16] | req.data_byte;
        default: rate_nxt[31:24] = rate_cur[31:24] | req.data_byte;
      endcase
    end
    if (p == whc_pkg::PosRateEnd && rate_nxt != expected_rate) begin
      err_nxt[whc_pkg::ErrRate] = 1'b1;
    end

    // Search for the data tag while no offset has been found yet.
    if (doff_cur == '0 && p >= whc_pkg::ScanFirst + 9'd3) begin
      if (win < {1'b0, scan_end} && last4_nxt == whc_pkg::TagData) begin
        doff_nxt = win + whc_pkg::DataSkip;
      end
    end

    // The search is over once a tag is found or no window below scan_end remains.
    lo       = (p >= whc_pkg::ScanFirst + 9'd2) ? p - 9'd2 : whc_pkg::ScanFirst;
    resolved = (doff_nxt != '0) || (lo >= {1'b0, scan_end});
    emit     = live && (req.end_of_stream || (resolved && p >= LastHdr));
    pos_nxt  = p + 9'd1;

    // Anything whose bytes did not all arrive counts as wrong.
    err_fin = err_nxt;
    if (p < LastHdr)              err_fin[whc_pkg::ErrShort] = 1'b1;
    if (p < whc_pkg::PosRiffEnd)  err_fin[whc_pkg::ErrRiff]  = 1'b1;
    if (p < whc_pkg::PosWaveEnd)  err_fin[whc_pkg::ErrWave]  = 1'b1;
    if (p < whc_pkg::PosFmtEnd)   err_fin[whc_pkg::ErrFmt]   = 1'b1;
    if (p < whc_pkg::PosRateEnd)  err_fin[whc_pkg::ErrRate]  = 1'b1;
    if (doff_nxt == '0)           err_fin[whc_pkg::ErrData]  = 1'b1;

    fin_nxt = emit;
    res.error_flags  = err_fin;
    res.header_ok    = (err_fin == '0);
    res.audio_offset = doff_nxt;
  end

  // File state; a byte that arrives while finished and without a start is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      rate_r  <= '0;
      last4_r <= '0;
      err_r   <= '0;
      fin_r   <= 1'b1;
      doff_r  <= '0;
    end else if (step_en && live) begin
      pos_r   <= pos_nxt;
      rate_r  <= rate_nxt;
      last4_r <= last4_nxt;
      err_r   <= emit ? err_fin : err_nxt;
      fin_r   <= fin_nxt;
      doff_r  <= doff_nxt;
    end
  end

endmodule

>>> tb/whc_verdict_checker.sv
// Checker for the WAV header checker: predicts each verdict from the byte requests and compares.
module whc_verdict_checker #(
  parameter int HEADER_BYTES = whc_pkg::HeaderBytesDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  whc_pkg::in_req_t  in_req,
  input  logic              out_valid,
  input  logic              out_stall,
  input  whc_pkg::out_res_t out_res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output int                mismatches,
  output int                pending
);

  // Parser state of the file under check.
  logic [8:0]  byte_pos;
  logic [31:0] rate_acc;
  logic [31:0] last4;
  logic [5:0]  err;
  logic        waiting;
  logic [8:0]  data_at;

  // Our copy of the configuration registers.
  logic [31:0] rate_cfg;
  logic [7:0]  scan_cfg;

  // Verdicts predicted but not yet seen on the result channel.
  whc_pkg::out_res_t verdict_q[$];

  // Prints one line per mismatch and counts it.
  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Advances the parser by one byte request and queues a verdict if one is due.
  task automatic parse_byte(input whc_pkg::in_req_t r);
    logic [8:0]        p;
    logic [8:0]        lo;
    logic              resolved;
    logic              emit;
    whc_pkg::out_res_t v;
    if (r.start_of_file) begin
      byte_pos = '0;
      rate_acc = '0;
      last4    = '0;
      err      = '0;
      waiting  = 1'b0;
      data_at  = '0;
    end else if (waiting) begin
      return;
    end
    p     = byte_pos;
    last4 = {last4[23:0], r.data_byte};

    // Tag and rate checks at the end of each header field.
    if (p == whc_pkg::PosRiffEnd && last4 != whc_pkg::TagRiff) err[whc_pkg::ErrRiff] = 1'b1;
    if (p == whc_pkg::PosWaveEnd && last4 != whc_pkg::TagWave) err[whc_pkg::ErrWave] = 1'b1;
    if (p == whc_pkg::PosFmtEnd && last4 != whc_pkg::TagFmt) err[whc_pkg::ErrFmt] = 1'b1;
    if (p inside {[whc_pkg::PosRateBeg:whc_pkg::PosRateEnd]}) begin
      rate_acc = rate_acc | (32'(r.data_byte) << (8 * (p - whc_pkg::PosRateBeg)));
    end
    if (p == whc_pkg::PosRateEnd && rate_acc != rate_cfg) err[whc_pkg::ErrRate] = 1'b1;

    // The data tag search looks at the window that ends with this byte.
    if (data_at == '0 && p >= whc_pkg::ScanFirst + 9'd3) begin
      if ((p - 9'd3) < {1'b0, scan_cfg} && last4 == whc_pkg::TagData) begin
        data_at = p - 9'd3 + whc_pkg::DataSkip;
      end
    end

    lo       = (p >= whc_pkg::ScanFirst + 9'd2) ? p - 9'd2 : whc_pkg::ScanFirst;
    resolved = (data_at != '0) || (lo >= {1'b0, scan_cfg});
    emit     = r.end_of_stream || (resolved && p >= HEADER_BYTES - 1);
    byte_pos = p + 9'd1;
    if (!emit) return;

    // Anything whose bytes never arrived counts as wrong.
    if (p < HEADER_BYTES - 1) err[whc_pkg::ErrShort] = 1'b1;
    if (p < whc_pkg::PosRiffEnd) err[whc_pkg::ErrRiff] = 1'b1;
    if (p < whc_pkg::PosWaveEnd) err[whc_pkg::ErrWave] = 1'b1;
    if (p < whc_pkg::PosFmtEnd) err[whc_pkg::ErrFmt] = 1'b1;
    if (p < whc_pkg::PosRateEnd) err[whc_pkg::ErrRate] = 1'b1;
    if (data_at == '0) err[whc_pkg::ErrData] = 1'b1;
    waiting = 1'b1;

    v.error_flags  = err;
    v.header_ok    = (err == '0);
    v.audio_offset = data_at;
    verdict_q.push_back(v);
  endtask

  // Watch the configuration port and both channels at each rising edge.
  always @(posedge clk) begin
    whc_pkg::out_res_t want;
    if (!rst_n) begin
      byte_pos   = '0;
      rate_acc   = '0;
      last4      = '0;
      err        = '0;
      waiting    = 1'b1;
      data_at    = '0;
      rate_cfg   = whc_pkg::ExpectedRateRst;
      scan_cfg   = whc_pkg::ScanEndRst;
      verdict_q.delete();
      mismatches = 0;
      pending    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == whc_pkg::RegExpectedRate) rate_cfg = pwdata;
        else scan_cfg = pwdata[7:0];
      end

      if (in_valid && !in_stall) parse_byte(in_req);

      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          flag_mismatch("result with no verdict pending", 32'(out_res), '0);
        end else begin
          want = verdict_q.pop_front();
          if (out_res.error_flags !== want.error_flags) begin
            flag_mismatch("error_flags", 32'(out_res.error_flags), 32'(want.error_flags));
          end
          if (out_res.header_ok !== want.header_ok) begin
            flag_mismatch("header_ok", 32'(out_res.header_ok), 32'(want.header_ok));
          end
          if (out_res.audio_offset !== want.audio_offset) begin
            flag_mismatch("audio_offset", 32'(out_res.audio_offset),
                          32'(want.audio_offset));
          end
        end
      end
      pending = verdict_q.size();
    end
  end

endmodule

>>> tb/wav_header_checker_tb.sv
// Testbench top for the WAV header checker: clock, reset, file stimulus, watchdog and verdict.
module wav_header_checker_tb;

  localparam logic [2:0] AddrRate    = {whc_pkg::RegExpectedRate, 2'b00};
  localparam logic [2:0] AddrScanEnd = {whc_pkg::RegScanEnd, 2'b00};
  localparam int IdleLimit   = 2000;
  localparam int ItemsTarget = 1050;
  localparam int FileMax     = 264;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  whc_pkg::in_req_t  in_req = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  whc_pkg::out_res_t out_res;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  int mismatches;
  int pending;

  // Stimulus state: the file image, our view of the registers and the idling switches.
  logic [7:0]  img [FileMax];
  logic [31:0] rate_now = whc_pkg::ExpectedRateRst;
  int          scan_now = int'(whc_pkg::ScanEndRst);
  int          items_sent = 0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;
  int          stall_left = 0;
  int          idle_cycles = 0;

  // Register settings at the extremes, run before the random settings.
  logic [31:0] edge_rates [5] = '{32'd0, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'd44100};
  int          edge_scans [5] = '{37, 255, 0, 36, 38};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  wav_header_checker uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  whc_verdict_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Result side stalls in runs: mostly short, now and then long.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (stalls_on && $urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 5);
    end
  end

  // Watchdog on cycles in which no request, result or register write is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Gap before a request: mostly none or short, a few long.
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Presents one byte request and holds it until the block takes it.
  task automatic push_byte(input logic [7:0] b, input logic sof, input logic eos);
    int               gap;
    whc_pkg::in_req_t q;
    gap = pick_gap();
    q.data_byte     = b;
    q.start_of_file = sof;
    q.end_of_stream = eos;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // One register write: setup phase, then access phase until pready.
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] rate, input int scan);
    apb_write(AddrRate, rate);
    apb_write(AddrScanEnd, 32'(scan[7:0]));
    rate_now = rate;
    scan_now = scan & 8'hFF;
  endtask

  // Builds a file image with the header tags, the rate and a data tag where asked.
  task automatic make_file(input int tag_at, input bit good_tags, input bit good_rate);
    int          idx;
    logic [31:0] rate_img;
    for (int i = 0; i < FileMax; i++) img[i] = 8'($urandom);
    for (int i = 0; i < 4; i++) begin
      img[i]      = whc_pkg::TagRiff[31 - 8 * i -: 8];
      img[8 + i]  = whc_pkg::TagWave[31 - 8 * i -: 8];
      img[12 + i] = whc_pkg::TagFmt[31 - 8 * i -: 8];
    end
    // A bad header has one bit flipped somewhere in its three tags.
    if (!good_tags) begin
      idx = $urandom_range(0, 11);
      if (idx >= 4) idx += 4;
      img[idx] = img[idx] ^ 8'(1 << $urandom_range(0, 7));
    end
    rate_img = good_rate ? rate_now : rate_now ^ (32'd1 << $urandom_range(0, 31));
    for (int i = 0; i < 4; i++) img[24 + i] = rate_img[8 * i +: 8];
    if (tag_at >= 0) begin
      for (int i = 0; i < 4; i++) img[tag_at + i] = whc_pkg::TagData[31 - 8 * i -: 8];
    end
  endtask

  // Sends the first len bytes of the image as one file.
  task automatic send_file(input int len, input bit with_eos);
    for (int i = 0; i < len; i++) push_byte(img[i], i == 0, with_eos && i == len - 1);
    items_sent += len;
  endtask

  // Ends a phase with a one-byte file, then waits until every verdict is out.
  task automatic close_phase();
    push_byte(8'($urandom), 1'b1, 1'b1);
    items_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // A phase of random files under the current register setting.
  task automatic run_phase();
    int n;
    int r;
    int tag_at;
    int vp;
    int len;
    int strays;
    bit eos_last;
    gaps_on   = $urandom_range(0, 3) != 0;
    stalls_on = $urandom_range(0, 3) != 0;
    n = (scan_now > 120) ? 1 : $urandom_range(1, 3);
    repeat (n) begin
      // Where the data tag sits: mostly inside the search, sometimes before or past it.
      r = $urandom_range(0, 99);
      if (r < 70) begin
        tag_at = (scan_now > 36) ? $urandom_range(36, scan_now - 1)
                                 : $urandom_range(36, 40);
      end
      else if (r < 85) tag_at = $urandom_range(28, 35);
      else if (r < 95) tag_at = scan_now + $urandom_range(0, 3);
      else tag_at = -1;

      // Position at which the verdict should fall, used to size the file.
      if (tag_at >= 36 && tag_at < scan_now) vp = tag_at + 3;
      else if (scan_now <= 36) vp = 0;
      else vp = scan_now + 2;
      if (vp < whc_pkg::HeaderBytesDef - 1) vp = whc_pkg::HeaderBytesDef - 1;

      // Cut short with an end marker, abandoned, or complete with a few trailing bytes.
      r = $urandom_range(0, 99);
      if (r < 20) begin
        len = $urandom_range(1, vp + 1);
        eos_last = 1'b1;
      end else if (r < 30) begin
        len = $urandom_range(1, vp);
        eos_last = 1'b0;
      end else begin
        len = vp + 1 + $urandom_range(0, 2);
        eos_last = $urandom_range(0, 2) == 0;
      end
      make_file(tag_at, $urandom_range(0, 9) != 0, $urandom_range(0, 5) != 0);
      send_file(len, eos_last);

      // Stray bytes with no start marker.
      if ($urandom_range(0, 9) == 0) begin
        strays = $urandom_range(1, 4);
        repeat (strays) push_byte(8'($urandom), 1'b0, 1'($urandom_range(0, 1)));
        items_sent += strays;
      end
    end
    close_phase();
  endtask

  initial begin
    logic [31:0] rate;
    int          r;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Bytes before any start marker are ignored, the end marker too.
    push_byte(8'($urandom), 1'b0, 1'b0);
    push_byte(8'($urandom), 1'b0, 1'b0);
    push_byte(8'hA5, 1'b0, 1'b1);
    // One-byte files: every flag set.
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);
    items_sent += 5;
    // Clean file with the data tag at the first window.
    make_file(36, 1'b1, 1'b1);
    send_file(44, 1'b0);
    // Data tag at the last window before scan_end, then at scan_end itself.
    make_file(99, 1'b1, 1'b1);
    send_file(103, 1'b0);
    make_file(100, 1'b1, 1'b1);
    send_file(103, 1'b1);
    // Restart in mid-file, then a file with a broken tag.
    make_file(40, 1'b1, 1'b1);
    send_file(20, 1'b0);
    make_file(40, 1'b0, 1'b1);
    send_file(44, 1'b0);
    // A header of all ones, cut at its last byte.
    for (int i = 0; i < 44; i++) img[i] = 8'hFF;
    send_file(44, 1'b1);
    // End of stream just before the rate is complete.
    make_file(36, 1'b1, 1'b0);
    send_file(27, 1'b1);
    // Data tag before the search starts.
    make_file(32, 1'b1, 1'b1);
    send_file(51, 1'b1);
    // Bytes after the verdict, the last with an end marker, are ignored.
    make_file(38, 1'b1, 1'b1);
    send_file(47, 1'b1);
    close_phase();

    // Register extremes, including a search window that is empty.
    for (int k = 0; k < 5; k++) begin
      set_config(edge_rates[k], edge_scans[k]);
      run_phase();
    end

    // Random settings until enough requests have gone through.
    while (items_sent < ItemsTarget) begin
      r = $urandom_range(0, 3);
      if (r == 0) rate = 32'd8000;
      else if (r == 1) rate = 32'd44100;
      else if (r == 2) rate = 32'd48000;
      else rate = $urandom;
      set_config(rate, ($urandom_range(0, 99) < 85) ? $urandom_range(37, 70) : $urandom_range(0, 255));
      run_phase();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
